// ===== src/plp_pkg.sv =====
// plp_pkg: shared constants, phase codes and the prefix lookup for the ping line parser
// no dependencies; imported by the channel interfaces and by ping_line_parser
package plp_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int LINE_LIMIT    = 64;

    // payload store addressing and fill counter widths
    localparam int PL_AW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int FILL_W = $clog2(PAYLOAD_DEPTH + 1);

    localparam int BYTE_W  = 8;
    localparam int SEQ_W   = 32;
    localparam int COUNT_W = 6;
    localparam int BCNT_W  = 7;

    localparam logic [BCNT_W-1:0] BCNT_MAX = '1;

    // parse phases
    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_FIRST   = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [2:0] PREFIX_LAST = 3'd4;

    // largest value that can still take another digit
    localparam logic [SEQ_W-1:0] SEQ_LIMIT_DIV10 = 32'd429496729;
    localparam logic [3:0]       SEQ_LIMIT_MOD10 = 4'd5;

    // "PING " one character per position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/plp_in_if.sv =====
// plp_in_if: valid/ready channel carrying one raw line byte per word
// depends on plp_pkg for field widths
interface plp_in_if;
    import plp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);

endinterface

// ===== src/plp_out_if.sv =====
// plp_out_if: valid/ready channel carrying one parse result per word
// depends on plp_pkg for field widths
interface plp_out_if;
    import plp_pkg::*;

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [SEQ_W-1:0]   sequence_number;
    logic [COUNT_W-1:0] payload_count;
    logic [BYTE_W-1:0]  payload_char;
    logic               final_result;

    modport source (output valid, output accepted, output sequence_number,
                    output payload_count, output payload_char, output final_result,
                    input ready);
    modport sink   (input valid, input accepted, input sequence_number,
                    input payload_count, input payload_char, input final_result,
                    output ready);

endinterface

// ===== src/ping_line_parser.sv =====
// ping_line_parser: parses "PING <seq> [payload]" text lines byte by byte
// depends on plp_pkg, plp_in_if and plp_out_if
//
//  channel    dir   word                                       modport
//  i_line     in    line_byte[7:0], line_end                   plp_in_if.sink
//  o_result   out   accepted, sequence_number[31:0],           plp_out_if.source
//                   payload_count[5:0], payload_char[7:0],
//                   final_result
//
// a byte is taken while the sequencer parses and the output register is free
// a line end that yields a single result loads the output register directly
// a line end with payload drains the memory word by word: ST_DRAIN reads, then ST_LOAD
// loads; the next line waits until every payload word is loaded, plus output stalls
// synchronous active-low reset clears the parse state and the output valid; the payload
// memory is never cleared, only entries written for the current line are read back
module ping_line_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plp_in_if.sink         i_line,
    plp_out_if.source      o_result
);
    import plp_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_PARSE = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;   // memory read in flight
    localparam logic [1:0] ST_LOAD  = 2'd2;   // read data ready for the output register

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    logic [1:0]        r_state;
    logic [1:0]        r_phase;
    logic [2:0]        r_ppos;
    logic [BCNT_W-1:0] r_bcnt;
    logic [SEQ_W-1:0]  r_acc;
    logic              r_brk;
    logic              r_rej;
    logic [FILL_W-1:0] r_fill;

    // drain context, captured at a line end that starts a payload drain
    logic [SEQ_W-1:0]  r_res_seq;
    logic [FILL_W-1:0] r_res_cnt;
    logic [FILL_W-1:0] r_rd_idx;

    // payload memory with registered read
    logic [BYTE_W-1:0] r_payload_mem [PAYLOAD_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // output register
    logic               r_out_valid;
    logic               r_out_acc;
    logic [SEQ_W-1:0]   r_out_seq;
    logic [COUNT_W-1:0] r_out_cnt;
    logic [BYTE_W-1:0]  r_out_char;
    logic               r_out_final;

    // ---------------------------------------------------------------
    // next values of the parse state for the byte on the input
    // ---------------------------------------------------------------
    logic [1:0]        n_phase;
    logic [2:0]        n_ppos;
    logic [BCNT_W-1:0] n_bcnt;
    logic [SEQ_W-1:0]  n_acc;
    logic              n_brk;
    logic              n_rej;
    logic [FILL_W-1:0] n_fill;
    logic              wr_en;

    logic [BYTE_W-1:0] in_b;
    logic              is_digit;
    logic [3:0]        digit;
    logic              digit_ovf;
    logic [SEQ_W-1:0]  acc_x10d;
    logic              line_ok;

    logic              out_free;
    logic              in_fire;
    logic              end_fire;
    logic              start_drain;
    logic              rd_last;

    assign in_b     = i_line.line_byte;
    assign is_digit = (in_b >= CH_ZERO) && (in_b <= CH_NINE);
    assign digit    = in_b[3:0];

    // overflow check before multiplying, then acc * 10 + d by shift and add
    assign digit_ovf = (r_acc > SEQ_LIMIT_DIV10)
                       || ((r_acc == SEQ_LIMIT_DIV10) && (digit > SEQ_LIMIT_MOD10));
    assign acc_x10d  = (r_acc << 3) + (r_acc << 1) + SEQ_W'(digit);

    always_comb begin
        n_phase = r_phase;
        n_ppos  = r_ppos;
        n_acc   = r_acc;
        n_brk   = r_brk;
        n_rej   = r_rej;
        n_fill  = r_fill;
        wr_en   = 1'b0;
        n_bcnt  = (r_bcnt == BCNT_MAX) ? r_bcnt : r_bcnt + 1'b1;

        if ((in_b == CH_CR) || (in_b == CH_LF)) begin
            // line break bytes are only legal as a trailing run
            n_brk = 1'b1;
        end else if (!r_rej) begin
            if (r_brk) begin
                n_rej = 1'b1;
            end else begin
                case (r_phase)
                    PH_PREFIX: begin
                        if (in_b != prefix_char(r_ppos)) begin
                            n_rej = 1'b1;
                        end else begin
                            n_ppos = r_ppos + 1'b1;
                            if (r_ppos == PREFIX_LAST) begin
                                n_phase = PH_FIRST;
                            end
                        end
                    end
                    PH_FIRST: begin
                        if (!is_digit || digit_ovf) begin
                            n_rej = 1'b1;
                        end else begin
                            n_acc = acc_x10d;
                        end
                        if (is_digit) begin
                            n_phase = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            if (digit_ovf) begin
                                n_rej = 1'b1;
                            end else begin
                                n_acc = acc_x10d;
                            end
                        end else if (in_b == CH_SPACE) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    default: begin
                        // payload: printable only, bounded by the memory depth
                        if ((in_b < CH_SPACE) || (in_b > CH_TILDE)
                            || (r_fill >= FILL_W'(PAYLOAD_DEPTH))) begin
                            n_rej = 1'b1;
                        end else begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign line_ok = !n_rej && (n_bcnt < BCNT_W'(LINE_LIMIT))
                     && ((n_phase == PH_DIGITS) || (n_phase == PH_PAYLOAD));

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_line.ready = (r_state == ST_PARSE) && out_free;
    assign in_fire      = i_line.valid && i_line.ready;
    assign end_fire     = in_fire && i_line.line_end;
    assign start_drain  = end_fire && line_ok && (n_fill != '0);
    assign rd_last      = (r_rd_idx == r_res_cnt - 1'b1);

    // ---------------------------------------------------------------
    // parse state and sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_PARSE;
            r_phase  <= PH_PREFIX;
            r_ppos   <= '0;
            r_bcnt   <= '0;
            r_acc    <= '0;
            r_brk    <= 1'b0;
            r_rej    <= 1'b0;
            r_fill   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (in_fire) begin
                if (i_line.line_end) begin
                    // every line end leaves a clean parser for the next line
                    r_phase <= PH_PREFIX;
                    r_ppos  <= '0;
                    r_bcnt  <= '0;
                    r_acc   <= '0;
                    r_brk   <= 1'b0;
                    r_rej   <= 1'b0;
                    r_fill  <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_ppos  <= n_ppos;
                    r_bcnt  <= n_bcnt;
                    r_acc   <= n_acc;
                    r_brk   <= n_brk;
                    r_rej   <= n_rej;
                    r_fill  <= n_fill;
                end
            end

            case (r_state)
                ST_PARSE: begin
                    if (start_drain) begin
                        r_rd_idx <= '0;
                        r_state  <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                        r_state  <= rd_last ? ST_PARSE : ST_DRAIN;
                    end
                end
                default: begin
                    r_state <= ST_PARSE;
                end
            endcase
        end
    end

    // drain context needs no reset
    always_ff @(posedge i_clk) begin
        if (start_drain) begin
            r_res_seq <= n_acc;
            r_res_cnt <= n_fill;
        end
    end

    // ---------------------------------------------------------------
    // payload memory: one write port while parsing, one registered read
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire && wr_en) begin
            r_payload_mem[r_fill[PL_AW-1:0]] <= in_b;
        end
        r_rd_data <= r_payload_mem[r_rd_idx[PL_AW-1:0]];
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((end_fire && !start_drain) || ((r_state == ST_LOAD) && out_free)) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_fire && !start_drain) begin
            // verdict only: rejected line or accepted line without payload
            r_out_acc   <= line_ok;
            r_out_seq   <= line_ok ? n_acc : '0;
            r_out_cnt   <= '0;
            r_out_char  <= '0;
            r_out_final <= 1'b1;
        end else if ((r_state == ST_LOAD) && out_free) begin
            r_out_acc   <= 1'b1;
            r_out_seq   <= r_res_seq;
            r_out_cnt   <= COUNT_W'(r_res_cnt);
            r_out_char  <= r_rd_data;
            r_out_final <= rd_last;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.accepted        = r_out_acc;
    assign o_result.sequence_number = r_out_seq;
    assign o_result.payload_count   = r_out_cnt;
    assign o_result.payload_char    = r_out_char;
    assign o_result.final_result    = r_out_final;

endmodule
